[rtl/core/u16550_pkg.sv]
// types and constants shared by the 16550 register block files
`timescale 1ns / 1ps
`default_nettype none

package u16550_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // register offsets
  localparam logic [2:0] ADDR_DATA  = 3'd0;
  localparam logic [2:0] ADDR_IER   = 3'd1;
  localparam logic [2:0] ADDR_IIR   = 3'd2;
  localparam logic [2:0] ADDR_LCR   = 3'd3;
  localparam logic [2:0] ADDR_MCR   = 3'd4;
  localparam logic [2:0] ADDR_LSR   = 3'd5;
  localparam logic [2:0] ADDR_MSR   = 3'd6;
  localparam logic [2:0] ADDR_SCR   = 3'd7;

  // interrupt identification codes
  localparam logic [2:0] IIR_NONE = 3'd1;
  localparam logic [2:0] IIR_THRE = 3'd2;
  localparam logic [2:0] IIR_RXD  = 3'd4;

  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned MCR_LOOP_BIT = 4;

  localparam logic [15:0] DIVISOR_RESET = 16'd12;
  localparam logic [7:0]  LCR_RESET     = 8'h03;
  localparam logic [7:0]  MCR_RESET     = 8'h08;
  localparam logic [7:0]  MSR_IDLE      = 8'hb0;
  localparam logic [1:0]  IIR_FIXED     = 2'b11;
  localparam logic [6:0]  LSR_FIXED     = 7'b0110000;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] addr;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_pulse;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       overflow;
  } out_word_t;

  // receive fifo control and status
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } fifo_stat_t;

endpackage

`default_nettype wire

[rtl/core/u16550_rx_fifo.sv]
// receive fifo with a prefetched head byte
`timescale 1ns / 1ps
`default_nettype none

module u16550_rx_fifo
  import u16550_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire fifo_ctrl_t ctrl_i,
  input  wire logic [7:0] wdata_i,
  output logic [7:0]      front_o,
  output fifo_stat_t      stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    mem [DEPTH];
  logic [PW-1:0] head_q, head_d;
  logic [PW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    front_q;

  function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      head_d  = wrap_inc(head_q);
      count_d = count_q + CW'(1);
    end
    if (ctrl_i.pop) begin
      tail_d  = wrap_inc(tail_q);
      count_d = count_d - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[head_q] <= wdata_i;
    end
  end

  // head byte register, bypassed when the push lands on the next read slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (head_q == tail_d)) begin
      front_q <= wdata_i;
    end else begin
      front_q <= mem[tail_d];
    end
  end

  assign front_o      = front_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.last  = (count_q == CW'(1));

endmodule

`default_nettype wire

[rtl/core/uart_16550_register_model.sv]
// top level of the simplified 16550 register block
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------
//  input   | in        | in_valid_i/in_stall_o | in_word_i  (op, addr, data)
//  output  | out       | out_valid_o/out_stall_i | out_word_o (read_data, irq,
//          |           |                       |   tx_valid, tx_byte, overflow)
//
// one word in and one word out per cycle when neither side stalls
// a word goes through the input register, then one pass of register logic
// into the output register
// the receive fifo head byte is prefetched into a register, so a data
// register read is served from that register without a stall
// reset clears all control and register state; fifo storage is not cleared
// an output stall holds the result word and backs up into the input register
`timescale 1ns / 1ps
`default_nettype none

module uart_16550_register_model
  import u16550_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // input stage
  logic     in_valid_q;
  in_word_t in_word_q;
  logic     in_accept;

  // output stage
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;

  // advance the word in the input register into the output register
  logic proc;

  // programmer visible state
  logic [15:0] div_q, div_d;
  logic [3:0]  ier_q, ier_d;
  logic [2:0]  iir_q, iir_d;
  logic [7:0]  lcr_q, lcr_d;
  logic [7:0]  mcr_q, mcr_d;
  logic [7:0]  scr_q, scr_d;
  logic        dr_q, dr_d;
  logic        txp_q, txp_d;

  // receive fifo
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  logic [7:0] fifo_front;

  logic dlab;
  logic loop;

  // received data ranks above transmit holding empty
  function automatic logic [2:0] iir_eval(logic [3:0] ier, logic dr, logic txp);
    if (ier[0] && dr) begin
      iir_eval = IIR_RXD;
    end else if (ier[1] && txp) begin
      iir_eval = IIR_THRE;
    end else begin
      iir_eval = IIR_NONE;
    end
  endfunction

  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign dlab = lcr_q[LCR_DLAB_BIT];
  assign loop = mcr_q[MCR_LOOP_BIT];

  u16550_rx_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (fifo_ctrl),
    .wdata_i (in_word_q.data),
    .front_o (fifo_front),
    .stat_o  (fifo_stat)
  );

  // register access logic for the word in the input register
  always_comb begin
    div_d      = div_q;
    ier_d      = ier_q;
    iir_d      = iir_q;
    lcr_d      = lcr_q;
    mcr_d      = mcr_q;
    scr_d      = scr_q;
    dr_d       = dr_q;
    txp_d      = txp_q;
    fifo_ctrl  = '0;
    out_word_d = '0;

    if (proc) begin
      case (in_word_q.op)
        OP_READ: begin
          case (in_word_q.addr)
            ADDR_DATA: begin
              if (dlab) begin
                out_word_d.read_data = div_q[7:0];
              end else begin
                // an empty read returns zero and pops nothing
                if (!fifo_stat.empty) begin
                  out_word_d.read_data = fifo_front;
                  fifo_ctrl.pop        = 1'b1;
                end
                if (fifo_stat.empty || fifo_stat.last) begin
                  dr_d = 1'b0;
                end
                iir_d                = iir_eval(ier_q, dr_d, txp_q);
                out_word_d.irq_pulse = (iir_d != IIR_NONE);
              end
            end
            ADDR_IER: begin
              out_word_d.read_data = dlab ? div_q[15:8] : {4'b0000, ier_q};
            end
            ADDR_IIR: begin
              out_word_d.read_data = {IIR_FIXED, 3'b000, iir_q};
              txp_d                = 1'b0;
              iir_d                = IIR_NONE;
            end
            ADDR_LCR: out_word_d.read_data = lcr_q;
            ADDR_MCR: out_word_d.read_data = mcr_q;
            ADDR_LSR: out_word_d.read_data = {LSR_FIXED, dr_q};
            ADDR_MSR: begin
              // loopback maps dtr/rts/out1/out2 onto the modem status inputs
              out_word_d.read_data = loop ? {mcr_q[3:2], mcr_q[0], mcr_q[1], 4'b0000}
                                          : MSR_IDLE;
            end
            default: out_word_d.read_data = scr_q;
          endcase
        end
        OP_WRITE: begin
          case (in_word_q.addr)
            ADDR_DATA: begin
              if (dlab) begin
                div_d[7:0] = in_word_q.data;
              end else begin
                txp_d = 1'b1;
                if (loop) begin
                  if (fifo_stat.full) begin
                    out_word_d.overflow = 1'b1;
                  end else begin
                    fifo_ctrl.push = 1'b1;
                  end
                  dr_d = 1'b1;
                end else begin
                  out_word_d.tx_valid = 1'b1;
                  out_word_d.tx_byte  = in_word_q.data;
                end
                iir_d                = iir_eval(ier_q, dr_d, txp_d);
                out_word_d.irq_pulse = (iir_d != IIR_NONE);
              end
            end
            ADDR_IER: begin
              if (dlab) begin
                div_d[15:8] = in_word_q.data;
              end else begin
                ier_d = in_word_q.data[3:0];
                if (ier_d != ier_q) begin
                  iir_d                = iir_eval(ier_d, dr_q, txp_q);
                  out_word_d.irq_pulse = (iir_d != IIR_NONE);
                end
              end
            end
            ADDR_LCR: lcr_d = in_word_q.data;
            ADDR_MCR: mcr_d = in_word_q.data;
            ADDR_SCR: scr_d = in_word_q.data;
            default: ;
          endcase
        end
        OP_RX: begin
          // line bytes are ignored in loopback
          if (!loop) begin
            if (fifo_stat.full) begin
              out_word_d.overflow = 1'b1;
            end else begin
              fifo_ctrl.push = 1'b1;
            end
            dr_d                 = 1'b1;
            iir_d                = iir_eval(ier_q, dr_d, txp_q);
            out_word_d.irq_pulse = (iir_d != IIR_NONE);
          end
        end
        default: ;
      endcase
    end
  end

  // control and register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      div_q       <= DIVISOR_RESET;
      ier_q       <= '0;
      iir_q       <= IIR_NONE;
      lcr_q       <= LCR_RESET;
      mcr_q       <= MCR_RESET;
      scr_q       <= '0;
      dr_q        <= 1'b0;
      txp_q       <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      div_q <= div_d;
      ier_q <= ier_d;
      iir_q <= iir_d;
      lcr_q <= lcr_d;
      mcr_q <= mcr_d;
      scr_q <= scr_d;
      dr_q  <= dr_d;
      txp_q <= txp_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_word_q <= in_word_i;
    end
    if (proc) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

[rtl/core/u16550_checker.sv]
// port level checks for the 16550 register block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module u16550_checker
  import u16550_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_word_t  in_word_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_word_o
);

  // a stalled result word stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  // a stalled input word is held by the sender
  a_in_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed while stalled");

  // the transmit byte is zero unless a byte goes to the line
  a_tx_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.tx_valid |-> out_word_o.tx_byte == 8'h00)
    else $error("tx byte set without tx valid");

  // a line transmit and a fifo overflow never come from the same word
  a_tx_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.tx_valid && out_word_o.overflow))
    else $error("tx and overflow in one result word");

endmodule

bind uart_16550_register_model u16550_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

[dv/tb_uart_16550_register_model.sv]
// self-checking testbench for the simplified 16550 register block
`timescale 1ns / 1ps

module tb_uart_16550_register_model;
  import u16550_pkg::*;

  localparam int unsigned RX_DEPTH   = 16;
  localparam int unsigned IDLE_LIMIT = 3000;  // cycles with no handshake at all
  localparam int unsigned RAND_ITEMS = 1700;
  localparam int unsigned SYNC_INDEX = 900;   // sender waits for a full drain here

  // one pending input word, optionally held back until the block is empty
  typedef struct {
    in_word_t w;
    bit       sync;
  } bus_item_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  uart_16550_register_model dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow copy of the register block, advanced once per accepted word
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_div  = DIVISOR_RESET;
  logic [3:0]  shadow_ier  = '0;
  logic [2:0]  shadow_iir  = IIR_NONE;
  logic [7:0]  shadow_lcr  = LCR_RESET;
  logic [7:0]  shadow_mcr  = MCR_RESET;
  logic [7:0]  shadow_scr  = '0;
  logic        shadow_dr   = 1'b0;
  logic        shadow_thre = 1'b0;
  logic [7:0]  shadow_rx [RX_DEPTH];
  logic [3:0]  shadow_head = '0;
  logic [3:0]  shadow_tail = '0;
  logic [4:0]  shadow_cnt  = '0;

  bus_item_t   bus_items[$];
  out_word_t   predicted_words[$];
  int unsigned mismatch_count = 0;
  int unsigned words_seen     = 0;
  bit          word_taken     = 1'b0;

  // generator-side view of the mode bits, so sequences can be shaped
  bit gen_dlab = 1'b0;
  bit gen_loop = 1'b0;

  initial begin
    for (int i = 0; i < RX_DEPTH; i++) shadow_rx[i] = '0;
  end

  // received data ranks above transmit holding empty
  function automatic logic iir_refresh();
    if (shadow_ier[0] && shadow_dr) shadow_iir = IIR_RXD;
    else if (shadow_ier[1] && shadow_thre) shadow_iir = IIR_THRE;
    else shadow_iir = IIR_NONE;
    return shadow_iir != IIR_NONE;
  endfunction

  // returns 1 when the byte is dropped on a full fifo
  function automatic logic rx_push(logic [7:0] b);
    if (shadow_cnt >= RX_DEPTH) return 1'b1;
    shadow_rx[shadow_head] = b;
    shadow_head = shadow_head + 4'd1;
    shadow_cnt  = shadow_cnt + 5'd1;
    return 1'b0;
  endfunction

  // an empty fifo reads as zero and pops nothing
  function automatic logic [7:0] rx_pop();
    logic [7:0] b;
    if (shadow_cnt == 0) return 8'h00;
    b = shadow_rx[shadow_tail];
    shadow_tail = shadow_tail + 4'd1;
    shadow_cnt  = shadow_cnt - 5'd1;
    return b;
  endfunction

  function automatic out_word_t uart_regs_step(in_word_t w);
    out_word_t r;
    logic      dlab;
    logic      loop_on;
    logic      ier_changed;
    r       = '0;
    dlab    = shadow_lcr[LCR_DLAB_BIT];
    loop_on = shadow_mcr[MCR_LOOP_BIT];
    case (w.op)
      OP_READ: begin
        case (w.addr)
          ADDR_DATA: begin
            if (dlab) begin
              r.read_data = shadow_div[7:0];
            end else begin
              r.read_data = rx_pop();
              if (shadow_cnt == 0) shadow_dr = 1'b0;
              r.irq_pulse = iir_refresh();
            end
          end
          ADDR_IER: r.read_data = dlab ? shadow_div[15:8] : {4'b0000, shadow_ier};
          ADDR_IIR: begin
            // reading the iir clears it along with the transmit-pending flag
            r.read_data = {IIR_FIXED, 3'b000, shadow_iir};
            shadow_thre = 1'b0;
            shadow_iir  = IIR_NONE;
          end
          ADDR_LCR: r.read_data = shadow_lcr;
          ADDR_MCR: r.read_data = shadow_mcr;
          ADDR_LSR: r.read_data = {LSR_FIXED, shadow_dr};
          ADDR_MSR: begin
            // loopback maps mcr bits onto the modem status inputs
            if (loop_on) r.read_data = {shadow_mcr[3], shadow_mcr[2], shadow_mcr[0],
                                        shadow_mcr[1], 4'b0000};
            else r.read_data = MSR_IDLE;
          end
          default: r.read_data = shadow_scr;
        endcase
      end
      OP_WRITE: begin
        case (w.addr)
          ADDR_DATA: begin
            if (dlab) begin
              shadow_div[7:0] = w.data;
            end else begin
              shadow_thre = 1'b1;
              if (loop_on) begin
                r.overflow = rx_push(w.data);
                shadow_dr  = 1'b1;
              end else begin
                r.tx_valid = 1'b1;
                r.tx_byte  = w.data;
              end
              r.irq_pulse = iir_refresh();
            end
          end
          ADDR_IER: begin
            if (dlab) begin
              shadow_div[15:8] = w.data;
            end else begin
              // iir only re-evaluated when an enable bit actually moves
              ier_changed = (shadow_ier != w.data[3:0]);
              shadow_ier  = w.data[3:0];
              if (ier_changed) r.irq_pulse = iir_refresh();
            end
          end
          ADDR_LCR: shadow_lcr = w.data;
          ADDR_MCR: shadow_mcr = w.data;
          ADDR_SCR: shadow_scr = w.data;
          default: ;  // iir, lsr and msr offsets ignore writes
        endcase
      end
      OP_RX: begin
        // line bytes are cut off while in loopback
        if (!loop_on) begin
          r.overflow  = rx_push(w.data);
          shadow_dr   = 1'b1;
          r.irq_pulse = iir_refresh();
        end
      end
      default: ;  // unused op, all fields zero
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic add_item(logic [1:0] op, logic [2:0] a, logic [7:0] d);
    bus_item_t it;
    it.w.op   = op;
    it.w.addr = a;
    it.w.data = d;
    it.sync   = (bus_items.size() == SYNC_INDEX);
    bus_items.push_back(it);
    if (op == OP_WRITE && a == ADDR_LCR) gen_dlab = d[LCR_DLAB_BIT];
    if (op == OP_WRITE && a == ADDR_MCR) gen_loop = d[MCR_LOOP_BIT];
  endtask

  // make sure offsets 0 and 1 reach the fifo, thr and ier
  task automatic clear_dlab();
    if (gen_dlab) add_item(OP_WRITE, ADDR_LCR, {1'b0, 7'($urandom_range(0, 127))});
  endtask

  task automatic add_random_sequence();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1: begin
        // stream of bytes into the receive fifo, often past full
        clear_dlab();
        n = $urandom_range(1, 20);
        repeat (n) begin
          if (gen_loop) add_item(OP_WRITE, ADDR_DATA, 8'($urandom));
          else add_item(OP_RX, 3'($urandom), 8'($urandom));
        end
      end
      2: begin
        // drain the fifo, running past empty now and then
        clear_dlab();
        n = $urandom_range(1, 20);
        repeat (n) begin
          add_item(OP_READ, ADDR_DATA, 8'($urandom));
          if ($urandom_range(0, 3) == 0) add_item(OP_READ, ADDR_LSR, 8'($urandom));
        end
      end
      3: begin
        // divisor latch access
        add_item(OP_WRITE, ADDR_LCR, {1'b1, 7'($urandom_range(0, 127))});
        add_item(OP_WRITE, ADDR_DATA, 8'($urandom));
        add_item(OP_WRITE, ADDR_IER, 8'($urandom));
        add_item(OP_READ, ADDR_DATA, 8'($urandom));
        add_item(OP_READ, ADDR_IER, 8'($urandom));
        add_item(OP_WRITE, ADDR_LCR, {1'b0, 7'($urandom_range(0, 127))});
      end
      4: begin
        clear_dlab();
        add_item(OP_WRITE, ADDR_IER, 8'($urandom));
        add_item(OP_READ, ADDR_IIR, 8'($urandom));
        add_item(OP_READ, ADDR_LSR, 8'($urandom));
        add_item(OP_READ, ADDR_IER, 8'($urandom));
      end
      5: begin
        add_item(OP_WRITE, ADDR_MCR, 8'($urandom));
        add_item(OP_READ, ADDR_MSR, 8'($urandom));
        add_item(OP_READ, ADDR_MCR, 8'($urandom));
      end
      6: begin
        clear_dlab();
        n = $urandom_range(1, 4);
        repeat (n) add_item(OP_WRITE, ADDR_DATA, 8'($urandom));
        if ($urandom_range(0, 1) == 0) add_item(OP_READ, ADDR_IIR, 8'($urandom));
      end
      7: begin
        add_item(OP_WRITE, ADDR_SCR, 8'($urandom));
        add_item(OP_READ, ADDR_SCR, 8'($urandom));
      end
      default: begin
        // noise: anything at all, unused op included
        n = $urandom_range(1, 6);
        repeat (n) add_item(2'($urandom), 3'($urandom), 8'($urandom));
      end
    endcase
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  initial begin
    // directed: reset values of every offset, empty fifo read first
    for (int a = 0; a < 8; a++) add_item(OP_READ, 3'(a), 8'h00);
    add_item(OP_WRITE, ADDR_SCR, 8'hff);
    add_item(OP_WRITE, ADDR_LCR, 8'h80);
    add_item(OP_WRITE, ADDR_DATA, 8'h00);
    add_item(OP_WRITE, ADDR_IER, 8'hff);
    add_item(OP_READ, ADDR_DATA, 8'h00);
    add_item(OP_READ, ADDR_IER, 8'h00);
    add_item(OP_WRITE, ADDR_LCR, 8'h03);
    add_item(OP_WRITE, ADDR_IER, 8'h0f);
    add_item(OP_WRITE, ADDR_IER, 8'hff);      // same low bits, no iir update
    add_item(OP_WRITE, ADDR_DATA, 8'ha5);     // byte out to the line
    add_item(OP_RX, 3'd7, 8'hff);
    add_item(OP_READ, ADDR_IIR, 8'hff);
    add_item(OP_READ, ADDR_DATA, 8'h00);
    add_item(OP_WRITE, ADDR_MCR, 8'h1f);      // loopback, all modem bits
    add_item(OP_RX, 3'd0, 8'h5a);             // ignored in loopback
    add_item(OP_WRITE, ADDR_DATA, 8'h3c);     // looped into the fifo
    add_item(OP_READ, ADDR_MSR, 8'h00);
    add_item(OP_WRITE, ADDR_IIR, 8'hff);
    add_item(OP_WRITE, ADDR_LSR, 8'hff);
    add_item(OP_WRITE, ADDR_MSR, 8'hff);
    add_item(OP_NONE, 3'd7, 8'hff);
    add_item(OP_WRITE, ADDR_MCR, 8'h00);
    // random: start with an overfilled fifo, then mixed sequences
    repeat (RX_DEPTH + 3) add_item(OP_RX, 3'($urandom), 8'($urandom));
    while (bus_items.size() < RAND_ITEMS) add_random_sequence();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!(bus_items.size() == 0 && !in_valid_i && predicted_words.size() == 0))
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (predicted_words.size() != 0) begin
      $error("%0d expected words never arrived", predicted_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_uart_16550_register_model passed");
    end else begin
      $display("tb_uart_16550_register_model failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of words with random gaps, changes at the falling edge
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    bus_item_t nxt;
    bit        send_next;
    send_next = 1'b0;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (bus_items.size() != 0 &&
                   !(bus_items[0].sync && predicted_words.size() != 0)) begin
        // a sync word waits until every expected word has come back
        nxt = bus_items.pop_front();
        send_next = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (send_next) in_word_i <= nxt.w;
      in_valid_i <= send_next;
    end
  end

  // input acceptance feeds the predictor
  always @(posedge clk_i) begin
    word_taken = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      word_taken = 1'b1;
      predicted_words.push_back(uart_regs_step(in_word_i));
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern, with one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned phase_cnt  = 0;
  int unsigned hold_left  = 0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk_i) begin
    bit stall_next;
    stall_next = 1'b0;
    if (!long_hold_done && words_seen >= 400) begin
      long_hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      phase_cnt++;
      if (phase_cnt[5:0] == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: stall_next = 1'b0;                              // free running
        1: stall_next = ($urandom_range(0, 3) == 0);      // light
        2: stall_next = ($urandom_range(0, 3) != 0);      // heavy
        default: stall_next = phase_cnt[0];               // alternating
      endcase
    end
    out_stall_i <= stall_next;
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each accepted word with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (predicted_words.size() == 0) begin
        $error("output word %h with nothing expected", out_word_o);
        mismatch_count++;
      end else begin
        exp_w = predicted_words.pop_front();
        check_field("read_data", exp_w.read_data, out_word_o.read_data);
        check_field("irq_pulse", 8'(exp_w.irq_pulse), 8'(out_word_o.irq_pulse));
        check_field("tx_valid", 8'(exp_w.tx_valid), 8'(out_word_o.tx_valid));
        check_field("tx_byte", exp_w.tx_byte, out_word_o.tx_byte);
        check_field("overflow", 8'(exp_w.overflow), 8'(out_word_o.overflow));
      end
    end
  end

  // watchdog: too long without any handshake means the block is stuck
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_uart_16550_register_model failed");
        $finish;
      end
    end
  end

endmodule
